@@ rtl/core/tss_pkg.sv @@
// tree sort stream package: beat types and cell control struct
// no dependencies; used by tss_cell and tree_sort_stream_core
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_item;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     run_end;
    logic                     overflow;
  } out_beat_t;

  typedef struct packed {
    logic ins;    // insert broadcast value this cycle
    logic drain;  // shift chain toward cell 0
    logic occ;    // cell holds a stored value
    logic tail;   // first free cell
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/tss_cell.sv @@
// one cell of the insertion chain: holds a single value, trades with neighbors
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_cell
  import tss_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire cell_ctl_t                ctl_i,
  input  wire logic signed [DATA_W-1:0] new_value_i,
  input  wire logic signed [DATA_W-1:0] left_value_i,
  input  wire logic                     left_shift_i,
  input  wire logic signed [DATA_W-1:0] right_value_i,
  output logic signed [DATA_W-1:0]      value_o,
  output logic                          shift_o
);

  logic signed [DATA_W-1:0] value_q, value_d;

  // equal values stay ahead of the new one, so strict compare
  assign shift_o = ctl_i.ins && ctl_i.occ && (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    if (ctl_i.drain) begin
      value_d = right_value_i;
    end else if (ctl_i.ins) begin
      if (left_shift_i) begin
        value_d = left_value_i;
      end else if (shift_o || ctl_i.tail) begin
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ rtl/core/tree_sort_stream_core.sv @@
// streaming sorter built as a chain of insertion cells
// depends on tss_pkg and tss_cell
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) takes one signed value
//   per beat; final_item marks the last value of a run. while loading, one beat
//   is taken every cycle: each value is compared against all cells at once and
//   the cells above its slot shift up by one.
//   after the final beat the block drains: the chain shifts toward cell 0 and
//   emits one beat per cycle in ascending order, run_end on the last one and
//   overflow on all of them if any value of the run found the chain full.
//   the drain emits one beat per stored value; the edge that takes the final
//   beat moves the state to drain, and the drain then loads the first result
//   into the output register. in_stall_o is high for the whole drain.
//   the output register holds its beat while out_stall_i is high; the drain
//   pauses with it.
//   reset clears the count, the overflow flag and the state; cell contents are
//   only read below the count and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module tree_sort_stream_core
  import tss_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             drop_q, drop_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic in_acc, full, do_ins, drain_load;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic                     cell_shift [CAPACITY];

  assign in_stall_o = (state_q == ST_DRAIN);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign do_ins     = in_acc && !full;
  assign drain_load = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] left_val, right_val;
    logic                     left_shift;

    assign ctl.ins   = do_ins;
    assign ctl.drain = drain_load;
    assign ctl.occ   = (CNT_W'(i) < count_q);
    assign ctl.tail  = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left_val   = cell_val[i-1];
      assign left_shift = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    tss_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_value_i  (in_data_i.value),
      .left_value_i (left_val),
      .left_shift_i (left_shift),
      .right_value_i(right_val),
      .value_o      (cell_val[i]),
      .shift_o      (cell_shift[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (in_data_i.final_item) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_load) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = cell_val[0];
          out_d.run_end      = (count_q == CNT_W'(1));
          out_d.overflow     = drop_q;
          count_d            = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_LOAD;
            drop_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> count_q != '0)
    else $error("drain with empty chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_run_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_load && count_q == CNT_W'(1) |=> state_q == ST_LOAD && !drop_q
      && out_valid_q && out_q.run_end)
    else $error("last drain beat did not close the run");

  a_full_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && full |=> count_q == CNT_W'(CAPACITY) && drop_q)
    else $error("value taken into a full chain");
`endif

endmodule

`default_nettype wire
